[hw/rtl/smf_pkg.sv]
// Shared types and constants for the slotted message FIFO.
package smf_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W = 7;
    localparam int STAT_W = 3;
    localparam int OP_W = 2;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;
    localparam int SLOTS_CFG_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 1'b1;

    localparam logic [SLOTS_CFG_W-1:0] SLOTS_IN_USE_RESET = 5'd16;
    localparam logic [LEN_W-1:0] SLOT_BYTES_RESET = 7'd64;

    localparam logic [OP_W-1:0] OP_PUBLISH = 2'd0;
    localparam logic [OP_W-1:0] OP_CONSUME = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
    localparam logic [OP_W-1:0] OP_SHUTDOWN = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd2;
    localparam logic [STAT_W-1:0] STAT_SHUT = 3'd3;
    localparam logic [STAT_W-1:0] STAT_TRUNC = 3'd4;

    // write offset saturates here
    localparam logic [LEN_W-1:0] OFFSET_MAX = 7'd127;

    // output queue
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_PW = 2;
    localparam int OBUF_LW = 3;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last_result;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  message_length;
    } result_t;

endpackage

[hw/rtl/slotted_message_fifo.sv]
// Slotted message FIFO: ring of message slots with publish and consume streams.
// Publish, flush and shutdown: one transaction per cycle while the result queue has room;
// result visible in the cycle after acceptance. Consume: length read then payload reads;
// one byte per cycle while the output queue has room; input stalls until the last read.
// Rate is set by the single read port of the payload memory and the 4-entry output queue.
// Reset clears pointers, count and flags, presets config registers; memories keep data.
module slotted_message_fifo #(
    parameter int SLOTS = 16,
    parameter int SLOT_BYTES = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // data_byte
    input  logic [2:0]                         s_axis_tuser,   // op[1:0], has_byte
    input  logic                               s_axis_tlast,   // end_of_message
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata,   // out_byte, message_length
    output logic [3:0]                         m_axis_tuser,   // byte_valid, status[2:0]
    output logic                               m_axis_tlast,   // last_result
    input  logic                               cfg_we,
    input  logic [smf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [smf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import smf_pkg::*;

    localparam int PW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = $clog2(SLOTS * SLOT_BYTES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LEN = 2'd1;
    localparam logic [1:0] ST_STREAM = 2'd2;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [SLOTS_CFG_W-1:0] slots_cfg_reg;
    logic [LEN_W-1:0]       bytes_cfg_reg;
    logic [PW-1:0]          write_slot_reg;
    logic [PW-1:0]          write_slot_next;
    logic [PW-1:0]          read_slot_reg;
    logic [PW-1:0]          read_slot_next;
    logic [CW-1:0]          occ_reg;
    logic [CW-1:0]          occ_next;
    logic [LEN_W-1:0]       wo_reg;
    logic [LEN_W-1:0]       wo_next;
    logic                   drop_reg;
    logic                   drop_next;
    logic                   shut_reg;
    logic                   shut_next;
    logic                   rd_valid_reg;
    logic                   rd_valid_next;
    logic                   rd_last_reg;
    logic                   rd_last_next;
    logic [PW-1:0]          cons_slot_reg;
    logic [PW-1:0]          cons_slot_next;
    logic [LEN_W-1:0]       cons_len_reg;
    logic [LEN_W-1:0]       cons_len_next;
    logic [LEN_W-1:0]       idx_reg;
    logic [LEN_W-1:0]       idx_next;

    logic [CW-1:0]          eff_slots;
    logic [LEN_W-1:0]       eff_bytes;
    logic                   accept;
    logic [OP_W-1:0]        op;
    logic                   has_byte;
    logic                   end_of_message;
    logic                   drop_now;
    logic [LEN_W-1:0]       wo_inc;
    logic [LEN_W-1:0]       len_eff;
    logic [OBUF_LW:0]       pend;
    logic                   issue_ok;

    logic                   pay_we;
    logic [AW-1:0]          pay_waddr;
    logic                   pay_re;
    logic [AW-1:0]          pay_raddr;
    logic [BYTE_W-1:0]      pay_rdata;
    logic                   len_we;
    logic [LEN_W-1:0]       len_wdata;
    logic                   len_re;
    logic [LEN_W-1:0]       len_rdata;

    logic                   push;
    result_t                push_data;
    result_t                out_data;
    logic [OBUF_LW-1:0]     level;

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [CW-1:0] lim);
        logic [CW-1:0] n;
        n = CW'(p) + CW'(1);
        return (n >= lim) ? '0 : PW'(n);
    endfunction

    always_comb
    begin
        if (slots_cfg_reg == '0)
        begin
            eff_slots = CW'(1);
        end
        else if (int'(slots_cfg_reg) > SLOTS)
        begin
            eff_slots = CW'(SLOTS);
        end
        else
        begin
            eff_slots = CW'(slots_cfg_reg);
        end

        if (bytes_cfg_reg == '0)
        begin
            eff_bytes = LEN_W'(1);
        end
        else if (int'(bytes_cfg_reg) > SLOT_BYTES)
        begin
            eff_bytes = LEN_W'(SLOT_BYTES);
        end
        else
        begin
            eff_bytes = bytes_cfg_reg;
        end
    end

    assign op = s_axis_tuser[1:0];
    assign has_byte = s_axis_tuser[2];
    assign end_of_message = s_axis_tlast;
    assign s_axis_tready = (state_reg == ST_IDLE) && !rd_valid_reg
                           && (level < OBUF_LW'(OBUF_DEPTH));
    assign accept = s_axis_tvalid && s_axis_tready;

    assign pend = {1'b0, level} + {{OBUF_LW{1'b0}}, rd_valid_reg};
    assign issue_ok = pend < (OBUF_LW + 1)'(OBUF_DEPTH);

    assign drop_now = drop_reg || ((wo_reg == '0) && (has_byte || end_of_message)
                                   && (occ_reg >= eff_slots));
    assign wo_inc = (has_byte && (wo_reg != OFFSET_MAX)) ? wo_reg + LEN_W'(1) : wo_reg;
    assign len_eff = (int'(len_rdata) > SLOT_BYTES) ? LEN_W'(SLOT_BYTES) : len_rdata;

    assign pay_waddr = AW'(int'(write_slot_reg) * SLOT_BYTES + int'(wo_reg));
    assign pay_raddr = AW'(int'(cons_slot_reg) * SLOT_BYTES + int'(idx_reg));

    always_comb
    begin
        state_next = state_reg;
        write_slot_next = write_slot_reg;
        read_slot_next = read_slot_reg;
        occ_next = occ_reg;
        wo_next = wo_reg;
        drop_next = drop_reg;
        shut_next = shut_reg;
        cons_slot_next = cons_slot_reg;
        cons_len_next = cons_len_reg;
        idx_next = idx_reg;
        rd_valid_next = 1'b0;
        rd_last_next = rd_last_reg;
        pay_we = 1'b0;
        pay_re = 1'b0;
        len_we = 1'b0;
        len_re = 1'b0;
        len_wdata = (wo_inc < eff_bytes) ? wo_inc : eff_bytes;
        push = 1'b0;
        push_data = '0;
        push_data.last_result = 1'b1;
        push_data.status = STAT_OK;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    push = 1'b1;
                    case (op)
                        OP_PUBLISH:
                        begin
                            if (shut_reg)
                            begin
                                push_data.status = STAT_SHUT;
                            end
                            else if (drop_now)
                            begin
                                push_data.status = STAT_FULL;
                                if (end_of_message)
                                begin
                                    drop_next = 1'b0;
                                    wo_next = '0;
                                end
                                else
                                begin
                                    drop_next = 1'b1;
                                end
                            end
                            else
                            begin
                                wo_next = wo_inc;
                                if (has_byte)
                                begin
                                    if (wo_reg < eff_bytes)
                                    begin
                                        pay_we = 1'b1;
                                    end
                                    else
                                    begin
                                        push_data.status = STAT_TRUNC;
                                    end
                                end
                                if (end_of_message)
                                begin
                                    wo_next = '0;
                                    if (occ_reg >= eff_slots)
                                    begin
                                        push_data.status = STAT_FULL;
                                    end
                                    else
                                    begin
                                        len_we = 1'b1;
                                        write_slot_next = adv(write_slot_reg, eff_slots);
                                        occ_next = occ_reg + CW'(1);
                                        if (wo_inc > eff_bytes)
                                        begin
                                            push_data.status = STAT_TRUNC;
                                        end
                                    end
                                end
                            end
                        end
                        OP_CONSUME:
                        begin
                            if (shut_reg)
                            begin
                                push_data.status = STAT_SHUT;
                            end
                            else if (occ_reg == '0)
                            begin
                                push_data.status = STAT_EMPTY;
                            end
                            else
                            begin
                                push = 1'b0;
                                len_re = 1'b1;
                                cons_slot_next = read_slot_reg;
                                read_slot_next = adv(read_slot_reg, eff_slots);
                                occ_next = occ_reg - CW'(1);
                                state_next = ST_LEN;
                            end
                        end
                        OP_FLUSH:
                        begin
                            write_slot_next = '0;
                            read_slot_next = '0;
                            occ_next = '0;
                            shut_next = 1'b0;
                            wo_next = '0;
                            drop_next = 1'b0;
                        end
                        OP_SHUTDOWN:
                        begin
                            shut_next = 1'b1;
                            wo_next = '0;
                            drop_next = 1'b0;
                        end
                        default:
                        begin
                            push = 1'b0;
                        end
                    endcase
                end
            end
            ST_LEN:
            begin
                if (len_eff == '0)
                begin
                    // empty message: one result, no payload
                    if (level < OBUF_LW'(OBUF_DEPTH))
                    begin
                        push = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cons_len_next = len_eff;
                    idx_next = '0;
                    state_next = ST_STREAM;
                end
            end
            ST_STREAM:
            begin
                if (issue_ok)
                begin
                    pay_re = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_last_next = (idx_reg + LEN_W'(1) == cons_len_reg);
                    idx_next = idx_reg + LEN_W'(1);
                    if (idx_reg + LEN_W'(1) == cons_len_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // payload byte returning from memory
        if (rd_valid_reg)
        begin
            push = 1'b1;
            push_data.out_byte = pay_rdata;
            push_data.byte_valid = 1'b1;
            push_data.last_result = rd_last_reg;
            push_data.status = STAT_OK;
            push_data.message_length = cons_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slots_cfg_reg <= SLOTS_IN_USE_RESET;
            bytes_cfg_reg <= SLOT_BYTES_RESET;
            write_slot_reg <= '0;
            read_slot_reg <= '0;
            occ_reg <= '0;
            wo_reg <= '0;
            drop_reg <= 1'b0;
            shut_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            write_slot_reg <= write_slot_next;
            read_slot_reg <= read_slot_next;
            occ_reg <= occ_next;
            wo_reg <= wo_next;
            drop_reg <= drop_next;
            shut_reg <= shut_next;
            rd_valid_reg <= rd_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SLOTS_IN_USE: slots_cfg_reg <= cfg_wdata[SLOTS_CFG_W-1:0];
                    CFG_SLOT_BYTES:   bytes_cfg_reg <= cfg_wdata[LEN_W-1:0];
                    default:          bytes_cfg_reg <= bytes_cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cons_slot_reg <= cons_slot_next;
        cons_len_reg <= cons_len_next;
        idx_reg <= idx_next;
        rd_last_reg <= rd_last_next;
    end

    smf_store #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_store (
        .clk       (clk),
        .pay_we    (pay_we),
        .pay_waddr (pay_waddr),
        .pay_wdata (s_axis_tdata),
        .pay_re    (pay_re),
        .pay_raddr (pay_raddr),
        .pay_rdata (pay_rdata),
        .len_we    (len_we),
        .len_waddr (write_slot_reg),
        .len_wdata (len_wdata),
        .len_re    (len_re),
        .len_raddr (read_slot_reg),
        .len_rdata (len_rdata)
    );

    smf_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .level     (level),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = {1'b0, out_data.message_length, out_data.out_byte};
    assign m_axis_tuser = {out_data.status, out_data.byte_valid};
    assign m_axis_tlast = out_data.last_result;

    // result queue never overflows
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (level < OBUF_LW'(OBUF_DEPTH) || m_axis_tready))
        else $error("result queue overflow");

    // payload read data only follows a streaming read
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> ($past(state_reg) == ST_STREAM))
        else $error("payload read without stream");

    // no input transaction while a consume is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == ST_IDLE && !rd_valid_reg))
        else $error("input accepted while busy");

    // occupancy bounded by the ring size
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(occ_reg) <= SLOTS)
        else $error("occupancy exceeds ring size");

endmodule

[hw/rtl/smf_store.sv]
// Payload and length memories, one write and one registered read port each.
module smf_store #(
    parameter int SLOTS = 16,
    parameter int SLOT_BYTES = 64
) (
    input  logic                                      clk,
    input  logic                                      pay_we,
    input  logic [$clog2(SLOTS*SLOT_BYTES)-1:0]       pay_waddr,
    input  logic [smf_pkg::BYTE_W-1:0]                pay_wdata,
    input  logic                                      pay_re,
    input  logic [$clog2(SLOTS*SLOT_BYTES)-1:0]       pay_raddr,
    output logic [smf_pkg::BYTE_W-1:0]                pay_rdata,
    input  logic                                      len_we,
    input  logic [$clog2(SLOTS)-1:0]                  len_waddr,
    input  logic [smf_pkg::LEN_W-1:0]                 len_wdata,
    input  logic                                      len_re,
    input  logic [$clog2(SLOTS)-1:0]                  len_raddr,
    output logic [smf_pkg::LEN_W-1:0]                 len_rdata
);
    import smf_pkg::*;

    localparam int PAY_DEPTH = SLOTS * SLOT_BYTES;

    logic [BYTE_W-1:0] pay_mem [PAY_DEPTH];
    logic [LEN_W-1:0]  len_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[pay_waddr] <= pay_wdata;
        end
        if (pay_re)
        begin
            pay_rdata <= pay_mem[pay_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        if (len_re)
        begin
            len_rdata <= len_mem[len_raddr];
        end
    end

endmodule

[hw/rtl/smf_obuf.sv]
// Small result queue in front of the output stream.
module smf_obuf (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  smf_pkg::result_t              push_data,
    output logic [smf_pkg::OBUF_LW-1:0]   level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output smf_pkg::result_t              out_data
);
    import smf_pkg::*;

    result_t              entry_reg [OBUF_DEPTH];
    logic [OBUF_PW-1:0]   wr_ptr_reg;
    logic [OBUF_PW-1:0]   wr_ptr_next;
    logic [OBUF_PW-1:0]   rd_ptr_reg;
    logic [OBUF_PW-1:0]   rd_ptr_next;
    logic [OBUF_LW-1:0]   count_reg;
    logic [OBUF_LW-1:0]   count_next;
    logic                 pop;

    assign out_valid = (count_reg != '0);
    assign out_data = entry_reg[rd_ptr_reg];
    assign level = count_reg;
    assign pop = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + OBUF_PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + OBUF_PW'(1) : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + OBUF_LW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - OBUF_LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[test/tb_slotted_message_fifo.sv]
`timescale 1ns / 100ps
// Self-checking testbench for slotted_message_fifo: directed and random stream traffic.
module tb_slotted_message_fifo;
    import smf_pkg::*;

    localparam int NUM_SLOTS = 16;
    localparam int MAX_SLOT_BYTES = 64;
    localparam int SETTLE_CYCLES = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASE_ITEMS = 12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;     // data_byte
    logic [2:0] s_axis_tuser = '0;     // op[1:0], has_byte
    logic s_axis_tlast = 1'b0;         // end_of_message
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b1;
    logic [15:0] m_axis_tdata;         // out_byte, message_length
    logic [3:0] m_axis_tuser;          // byte_valid, status[2:0]
    logic m_axis_tlast;                // last_result
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // shadow of the ring
    logic [BYTE_W-1:0] shadow_payload [NUM_SLOTS*MAX_SLOT_BYTES];
    logic [LEN_W-1:0] shadow_length [NUM_SLOTS];
    int wr_slot = 0;
    int rd_slot = 0;
    int occupied = 0;
    int wr_offset = 0;
    bit dropping = 1'b0;
    bit shut_down = 1'b0;
    logic [SLOTS_CFG_W-1:0] reg_slots = SLOTS_IN_USE_RESET;
    logic [LEN_W-1:0] reg_bytes = SLOT_BYTES_RESET;

    result_t expected_results [$];
    result_t want_result;
    int mismatch_count = 0;
    int input_count = 0;
    int result_count = 0;
    int setting_count = 1;
    bit sender_gaps = 1'b1;
    bit receiver_stalls = 1'b1;

    slotted_message_fifo #(
        .SLOTS(NUM_SLOTS),
        .SLOT_BYTES(MAX_SLOT_BYTES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #4 clk = ~clk;

    function automatic int ring_depth();
        if (reg_slots == 0)
            return 1;
        if (reg_slots > NUM_SLOTS)
            return NUM_SLOTS;
        return int'(reg_slots);
    endfunction

    function automatic int slot_capacity();
        if (reg_bytes == 0)
            return 1;
        if (reg_bytes > MAX_SLOT_BYTES)
            return MAX_SLOT_BYTES;
        return int'(reg_bytes);
    endfunction

    function automatic int next_slot(int p);
        return (p + 1 >= ring_depth()) ? 0 : p + 1;
    endfunction

    function automatic void push_result(logic [BYTE_W-1:0] b, logic valid, logic last,
                                        logic [STAT_W-1:0] st, logic [LEN_W-1:0] len);
        result_t r;
        r.out_byte = b;
        r.byte_valid = valid;
        r.last_result = last;
        r.status = st;
        r.message_length = len;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_publish(logic [BYTE_W-1:0] data, logic has, logic eom);
        logic [STAT_W-1:0] st;
        int len;
        st = STAT_OK;
        if (shut_down)
        begin
            push_result('0, 1'b0, 1'b1, STAT_SHUT, '0);
            return;
        end
        if (wr_offset == 0 && !dropping && (has || eom) && occupied >= ring_depth())
            dropping = 1'b1;
        if (dropping)
        begin
            if (eom)
            begin
                dropping = 1'b0;
                wr_offset = 0;
            end
            push_result('0, 1'b0, 1'b1, STAT_FULL, '0);
            return;
        end
        if (has)
        begin
            if (wr_offset < slot_capacity())
                shadow_payload[wr_slot*MAX_SLOT_BYTES + wr_offset] = data;
            else
                st = STAT_TRUNC;
            if (wr_offset < OFFSET_MAX)
                wr_offset++;
        end
        if (eom)
        begin
            if (occupied >= ring_depth())
            begin
                st = STAT_FULL;
            end
            else
            begin
                len = (wr_offset < slot_capacity()) ? wr_offset : slot_capacity();
                shadow_length[wr_slot] = LEN_W'(len);
                wr_slot = next_slot(wr_slot);
                occupied++;
                if (wr_offset > slot_capacity())
                    st = STAT_TRUNC;
            end
            wr_offset = 0;
        end
        push_result('0, 1'b0, 1'b1, st, '0);
    endfunction

    function automatic void predict_consume();
        int slot;
        int len;
        if (shut_down)
        begin
            push_result('0, 1'b0, 1'b1, STAT_SHUT, '0);
            return;
        end
        if (occupied == 0)
        begin
            push_result('0, 1'b0, 1'b1, STAT_EMPTY, '0);
            return;
        end
        slot = rd_slot;
        len = int'(shadow_length[slot]);
        rd_slot = next_slot(rd_slot);
        occupied--;
        if (len == 0)
        begin
            push_result('0, 1'b0, 1'b1, STAT_OK, '0);
            return;
        end
        for (int i = 0; i < len; i++)
            push_result(shadow_payload[slot*MAX_SLOT_BYTES + i], 1'b1, i == len - 1,
                        STAT_OK, LEN_W'(len));
    endfunction

    function automatic void predict_transaction(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                                logic has, logic eom);
        case (op)
            OP_PUBLISH: predict_publish(data, has, eom);
            OP_CONSUME: predict_consume();
            default:
            begin
                if (op == OP_FLUSH)
                begin
                    wr_slot = 0;
                    rd_slot = 0;
                    occupied = 0;
                    shut_down = 1'b0;
                end
                else
                begin
                    shut_down = 1'b1;
                end
                wr_offset = 0;
                dropping = 1'b0;
                push_result('0, 1'b0, 1'b1, STAT_OK, '0);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_count++;
            if (expected_results.size() == 0)
            begin
                $error("result transaction with none expected: byte %0d status %0d",
                       m_axis_tdata[7:0], m_axis_tuser[3:1]);
                mismatch_count++;
            end
            else
            begin
                want_result = expected_results.pop_front();
                check_field("out_byte", 16'(want_result.out_byte), 16'(m_axis_tdata[7:0]));
                check_field("byte_valid", 16'(want_result.byte_valid), 16'(m_axis_tuser[0]));
                check_field("last_result", 16'(want_result.last_result), 16'(m_axis_tlast));
                check_field("status", 16'(want_result.status), 16'(m_axis_tuser[3:1]));
                check_field("message_length", 16'(want_result.message_length),
                            16'(m_axis_tdata[14:8]));
            end
        end
    end

    initial
    begin : receiver
        int n;
        forever
        begin
            @(negedge clk);
            if (receiver_stalls && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 6);
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $error("no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_results.size());
        $display("Verification failed");
        $finish;
    end

    task automatic send_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data, logic has,
                             logic eom);
        int gap;
        @(negedge clk);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= {has, op};
        s_axis_tlast <= eom;
        predict_transaction(op, data, has, eom);
        do @(posedge clk); while (!s_axis_tready);
        input_count++;
    endtask

    task automatic publish_message(int len);
        if (len == 0)
        begin
            send_item(OP_PUBLISH, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
            return;
        end
        for (int i = 0; i < len; i++)
            send_item(OP_PUBLISH, 8'($urandom_range(0, 255)), 1'b1, i == len - 1);
    endtask

    // hold off until every expected result has been taken
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SLOTS_IN_USE)
            reg_slots = value[SLOTS_CFG_W-1:0];
        else
            reg_bytes = value[LEN_W-1:0];
    endtask

    task automatic start_phase(logic [CFG_DATA_W-1:0] slots, logic [CFG_DATA_W-1:0] bytes);
        send_item(OP_FLUSH, 8'h00, 1'b0, 1'b0);
        write_register(CFG_SLOTS_IN_USE, slots);
        write_register(CFG_SLOT_BYTES, bytes);
        setting_count++;
    endtask

    task automatic test_directed_ops();
        send_item(OP_CONSUME, 8'h00, 1'b0, 1'b0);
        send_item(OP_PUBLISH, 8'hFF, 1'b0, 1'b0);
        send_item(OP_PUBLISH, 8'h00, 1'b1, 1'b0);
        send_item(OP_PUBLISH, 8'hFF, 1'b1, 1'b1);
        send_item(OP_PUBLISH, 8'h00, 1'b0, 1'b1);
        send_item(OP_PUBLISH, 8'hA5, 1'b1, 1'b1);
        send_item(OP_CONSUME, 8'hFF, 1'b1, 1'b1);
        send_item(OP_CONSUME, 8'h00, 1'b0, 1'b0);
        // shutdown drops the open message
        send_item(OP_PUBLISH, 8'h5A, 1'b1, 1'b0);
        send_item(OP_SHUTDOWN, 8'h00, 1'b0, 1'b0);
        send_item(OP_PUBLISH, 8'h3C, 1'b1, 1'b1);
        send_item(OP_CONSUME, 8'h00, 1'b0, 1'b0);
        send_item(OP_FLUSH, 8'hFF, 1'b1, 1'b1);
        send_item(OP_CONSUME, 8'h00, 1'b0, 1'b0);
        // flush drops the open message
        send_item(OP_PUBLISH, 8'hC3, 1'b1, 1'b0);
        send_item(OP_FLUSH, 8'h00, 1'b0, 1'b0);
        send_item(OP_CONSUME, 8'h00, 1'b0, 1'b0);
    endtask

    task automatic test_full_and_truncation();
        start_phase(7'd1, 7'd2);
        send_item(OP_PUBLISH, 8'h11, 1'b1, 1'b0);
        send_item(OP_PUBLISH, 8'h22, 1'b1, 1'b0);
        send_item(OP_PUBLISH, 8'h33, 1'b1, 1'b1);
        send_item(OP_PUBLISH, 8'h44, 1'b1, 1'b0);
        send_item(OP_PUBLISH, 8'h55, 1'b1, 1'b1);
        send_item(OP_PUBLISH, 8'h00, 1'b0, 1'b1);
        send_item(OP_CONSUME, 8'h00, 1'b0, 1'b0);
        // ring shrinks under an open message: its commit is dropped
        start_phase(7'd2, 7'd64);
        send_item(OP_PUBLISH, 8'h66, 1'b1, 1'b1);
        send_item(OP_PUBLISH, 8'h77, 1'b1, 1'b0);
        write_register(CFG_SLOTS_IN_USE, 7'd1);
        send_item(OP_PUBLISH, 8'h88, 1'b1, 1'b1);
        send_item(OP_CONSUME, 8'h00, 1'b0, 1'b0);
        send_item(OP_CONSUME, 8'h00, 1'b0, 1'b0);
    endtask

    task automatic random_phase(int budget);
        int sent;
        int pick;
        int len;
        int cap;
        sent = 0;
        cap = slot_capacity();
        while (sent < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                if (cap < 13 && $urandom_range(0, 7) == 0)
                    len = $urandom_range(0, cap + 3);
                else
                    len = $urandom_range(0, (cap < 5) ? cap + 1 : 6);
                if (len == 0)
                begin
                    publish_message(0);
                    sent++;
                end
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_item(OP_CONSUME, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                        sent++;
                    end
                    send_item(OP_PUBLISH, 8'($urandom_range(0, 255)), 1'b1, i == len - 1);
                    sent++;
                    if (i < len - 1 && $urandom_range(0, 15) == 0)
                        break;
                end
            end
            else if (pick < 85)
            begin
                send_item(OP_CONSUME, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                sent++;
            end
            else if (pick < 90)
            begin
                send_item(OP_PUBLISH, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
                sent++;
            end
            else if (pick < 95)
            begin
                send_item(OP_FLUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                send_item(OP_SHUTDOWN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                send_item(OP_PUBLISH, 8'($urandom_range(0, 255)), 1'b1,
                          1'($urandom_range(0, 1)));
                send_item(OP_CONSUME, 8'h00, 1'b0, 1'b0);
                send_item(OP_FLUSH, 8'h00, 1'b0, 1'b0);
                sent += 4;
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++)
        begin
            sender_gaps = (phase == 4) ? 1'b0 : 1'($urandom_range(0, 1));
            receiver_stalls = (phase == 4) ? 1'b0 : 1'($urandom_range(0, 1));
            case (phase)
                0: start_phase(7'd0, 7'd0);
                1: start_phase(7'd1, 7'd1);
                2: start_phase(7'd3, 7'd5);
                3: start_phase(7'($urandom_range(2, 16)), 7'($urandom_range(2, 12)));
                default: start_phase(7'd31, 7'd127);
            endcase
            random_phase(RANDOM_PHASE_ITEMS);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_ops();
        test_full_and_truncation();
        test_random_traffic();
        drain();
        $display("Ran %0d input and %0d result transactions over %0d register settings,",
                 input_count, result_count, setting_count);
        $display("covering full, empty, truncated, shut-down, zero-length messages and "
                 , "out-of-range register values.");
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/smf_pkg.sv
hw/rtl/smf_store.sv
hw/rtl/smf_obuf.sv
hw/rtl/slotted_message_fifo.sv
test/tb_slotted_message_fifo.sv
